// File: rtl/atan2_polynomial_approx_top_defines.svh
// ----------------------------------------------------------------------------
// atan2 assertion macros
// shared assertion wrappers for the atan2 checker
// ----------------------------------------------------------------------------
`ifndef ATAN2_POLYNOMIAL_APPROX_TOP_DEFINES_SVH
`define ATAN2_POLYNOMIAL_APPROX_TOP_DEFINES_SVH

// same-cycle implication, masked during reset
`define ATAN2_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("atan2 check failed");

// next-cycle implication, masked during reset
`define ATAN2_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("atan2 check failed");

// next-cycle implication, active through reset
`define ATAN2_ASSERT_RST(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("atan2 check failed");

`endif

// File: rtl/atan2_pkg.sv
// ----------------------------------------------------------------------------
// atan2 package
// widths, coefficients and sideband type shared by the atan2 pipeline
// ----------------------------------------------------------------------------
package atan2_pkg;

  localparam int COORD_WIDTH     = 16;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int ANGLE_WIDTH     = ANGLE_FRAC_BITS + 3;
  localparam int INNER_FRAC      = 16;

  localparam int MAG_W  = COORD_WIDTH;
  localparam int QUO_W  = INNER_FRAC + 1;
  localparam int COEF_W = INNER_FRAC;
  localparam int R_W    = INNER_FRAC + 2;

  localparam int IN_DATA_W  = ((2 * COORD_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((ANGLE_WIDTH + 7) / 8) * 8;

  localparam logic [COEF_W-1:0] K_C3      = COEF_W'(3047);
  localparam logic [COEF_W-1:0] K_C2      = COEF_W'(10441);
  localparam logic [COEF_W-1:0] K_C1      = COEF_W'(21471);
  localparam logic [R_W-1:0]    K_HALF_PI = R_W'(102944);
  localparam logic [R_W-1:0]    K_PI      = R_W'(205887);

  localparam int SH_UP = (ANGLE_FRAC_BITS >= INNER_FRAC) ? ANGLE_FRAC_BITS - INNER_FRAC : 0;
  localparam int SH_DN = (ANGLE_FRAC_BITS < INNER_FRAC) ? INNER_FRAC - ANGLE_FRAC_BITS : 1;
  localparam int EXT_W = R_W + 1 + SH_UP;
  localparam logic [EXT_W-1:0] ROUND_K = EXT_W'(1) << (SH_DN - 1);

  typedef struct packed {
    logic zero;
    logic swap;
    logic xneg;
    logic yneg;
  } side_t;

endpackage

// File: rtl/atan2_div_cell.sv
// ----------------------------------------------------------------------------
// atan2 divider cell
// one restoring-division step: produces one quotient bit per cell
// ----------------------------------------------------------------------------
module atan2_div_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [atan2_pkg::MAG_W-1:0]   rem_in,
  input  logic                          bit_in,
  input  logic [atan2_pkg::MAG_W-1:0]   div_in,
  input  logic [atan2_pkg::QUO_W-1:0]   quo_in,
  input  atan2_pkg::side_t              side_in,
  output logic                          out_valid,
  output logic [atan2_pkg::MAG_W-1:0]   rem_out,
  output logic [atan2_pkg::MAG_W-1:0]   div_out,
  output logic [atan2_pkg::QUO_W-1:0]   quo_out,
  output atan2_pkg::side_t              side_out
);

  logic [atan2_pkg::MAG_W:0]   trial;
  logic [atan2_pkg::MAG_W:0]   diff;
  logic                        ge;
  logic [atan2_pkg::MAG_W-1:0] rem_next;

  always_comb begin
    trial    = {rem_in, bit_in};
    diff     = trial - {1'b0, div_in};
    ge       = (trial >= {1'b0, div_in});
    rem_next = ge ? diff[atan2_pkg::MAG_W-1:0] : trial[atan2_pkg::MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= rem_next;
      div_out  <= div_in;
      quo_out  <= {quo_in[atan2_pkg::QUO_W-2:0], ge};
      side_out <= side_in;
    end
  end

endmodule

// File: rtl/atan2_poly.sv
// ----------------------------------------------------------------------------
// atan2 polynomial and fold
// odd minimax polynomial on the ratio, octant fold, output scaling and sign
// ----------------------------------------------------------------------------
module atan2_poly (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [atan2_pkg::QUO_W-1:0]       a_in,
  input  atan2_pkg::side_t                  side_in,
  output logic                              out_valid,
  output logic [atan2_pkg::ANGLE_WIDTH-1:0] angle
);

  localparam int QW = atan2_pkg::QUO_W;
  localparam int CW = atan2_pkg::COEF_W;
  localparam int RW = atan2_pkg::R_W;
  localparam int IF = atan2_pkg::INNER_FRAC;

  logic [6:0] v;

  // stage 1: s = a*a
  logic [QW-1:0]          a1, s1;
  atan2_pkg::side_t       sd1;
  // stage 2: t1
  logic [QW-1:0]          a2, s2;
  logic [CW-1:0]          t2;
  atan2_pkg::side_t       sd2;
  // stage 3: q
  logic [QW-1:0]          a3, s3;
  logic [CW-1:0]          q3;
  atan2_pkg::side_t       sd3;
  // stage 4: u = q*s
  logic [QW-1:0]          a4;
  logic [CW-1:0]          u4;
  atan2_pkg::side_t       sd4;
  // stage 5: r
  logic [RW-1:0]          r5;
  atan2_pkg::side_t       sd5;
  // stage 6: folded r
  logic [RW-1:0]          r6;
  atan2_pkg::side_t       sd6;

  logic [2*QW-1:0]        p_ss;
  logic [CW+QW-1:0]       p_cs;
  logic [CW+QW-1:0]       p_ts;
  logic [CW+QW-1:0]       p_qs;
  logic [CW+QW-1:0]       p_ua;
  logic [RW-1:0]          f_half;
  logic [RW-1:0]          f_pi;
  logic [atan2_pkg::EXT_W-1:0]       r_ext;
  logic [atan2_pkg::EXT_W-1:0]       scaled;
  logic [atan2_pkg::ANGLE_WIDTH-1:0] mag_out;
  logic [atan2_pkg::ANGLE_WIDTH-1:0] angle_next;

  always_comb begin
    p_ss   = a_in * a_in;
    p_cs   = atan2_pkg::K_C3 * s1;
    p_ts   = t2 * s2;
    p_qs   = q3 * s3;
    p_ua   = u4 * a4;
    f_half = sd5.swap ? (atan2_pkg::K_HALF_PI - r5) : r5;
    f_pi   = sd5.xneg ? (atan2_pkg::K_PI - f_half) : f_half;
    r_ext  = atan2_pkg::EXT_W'(r6);
    if (atan2_pkg::ANGLE_FRAC_BITS >= IF) begin
      scaled = r_ext << atan2_pkg::SH_UP;
    end else begin
      scaled = (r_ext + atan2_pkg::ROUND_K) >> atan2_pkg::SH_DN;
    end
    mag_out = atan2_pkg::ANGLE_WIDTH'(scaled);
    if (sd6.zero) begin
      angle_next = '0;
    end else if (sd6.yneg) begin
      angle_next = '0 - mag_out;
    end else begin
      angle_next = mag_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1  <= a_in;
      s1  <= p_ss[IF +: QW];
      sd1 <= side_in;

      a2  <= a1;
      s2  <= s1;
      t2  <= atan2_pkg::K_C2 - CW'(p_cs[CW+QW-1:IF]);
      sd2 <= sd1;

      a3  <= a2;
      s3  <= s2;
      q3  <= atan2_pkg::K_C1 - CW'(p_ts[CW+QW-1:IF]);
      sd3 <= sd2;

      a4  <= a3;
      u4  <= CW'(p_qs[CW+QW-1:IF]);
      sd4 <= sd3;

      r5  <= RW'(a4) - RW'(p_ua[CW+QW-1:IF]);
      sd5 <= sd4;

      r6  <= f_pi;
      sd6 <= sd5;

      angle <= angle_next;
    end
  end

  assign out_valid = v[6];

endmodule

// File: rtl/atan2_polynomial_approx_top.sv
// ----------------------------------------------------------------------------
// atan2 polynomial approximation
// four-quadrant arctangent of a signed vector, signed Q3.13 radians out
// ----------------------------------------------------------------------------
// usage
//   slave side takes one (y, x) vector per transfer on s_tdata; master side
//   returns one angle per transfer on m_tdata, in order, one for each input
//   from input transfer to output valid an item passes the magnitude and
//   min/max registers, 17 divider cells (one quotient bit each), five
//   multiplier stages for the polynomial, one fold and one output register
//   throughput, unless the receiver stalls, is one transfer per cycle, set by
//   the cell chain and registered multipliers, each taking an item every cycle
//   all stages move together on one enable; s_tready is high whenever the
//   output register is empty or being taken in the same cycle
//   when the receiver stalls with a result held, the whole pipeline holds and
//   s_tready drops; nothing is lost or repeated
//   the zero vector gives angle 0
//   reset (rst, synchronous) empties the pipeline; partly computed items are
//   dropped and m_tvalid goes low
// ----------------------------------------------------------------------------
module atan2_polynomial_approx_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [atan2_pkg::IN_DATA_W-1:0]  s_tdata,  // y_coord, x_coord
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [atan2_pkg::OUT_DATA_W-1:0] m_tdata   // angle
);

  localparam int W  = atan2_pkg::COORD_WIDTH;
  localparam int MW = atan2_pkg::MAG_W;
  localparam int QW = atan2_pkg::QUO_W;

  logic en;

  logic [W-1:0]  y_coord, x_coord;
  logic [MW-1:0] ay_next, ax_next;

  logic          va, yneg_a, xneg_a;
  logic [MW-1:0] ay_a, ax_a;

  logic              vb;
  logic [MW-1:0]     mn_b, mx_b;
  atan2_pkg::side_t  side_b;

  logic             cv    [0:QW];
  logic [MW-1:0]    crem  [0:QW];
  logic [MW-1:0]    cdiv  [0:QW];
  logic [QW-1:0]    cquo  [0:QW];
  atan2_pkg::side_t cside [0:QW];

  logic                             poly_valid;
  logic [atan2_pkg::ANGLE_WIDTH-1:0] angle;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  assign y_coord = s_tdata[W-1:0];
  assign x_coord = s_tdata[2*W-1:W];

  always_comb begin
    ay_next = y_coord[W-1] ? MW'(~y_coord + 1'b1) : MW'(y_coord);
    ax_next = x_coord[W-1] ? MW'(~x_coord + 1'b1) : MW'(x_coord);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else if (en) begin
      va <= s_tvalid;
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ay_a   <= ay_next;
      ax_a   <= ax_next;
      yneg_a <= y_coord[W-1];
      xneg_a <= x_coord[W-1];

      mn_b        <= (ax_a > ay_a) ? ay_a : ax_a;
      mx_b        <= (ax_a > ay_a) ? ax_a : ay_a;
      side_b.zero <= (ax_a == '0) && (ay_a == '0);
      side_b.swap <= (ay_a > ax_a);
      side_b.xneg <= xneg_a;
      side_b.yneg <= yneg_a;
    end
  end

  assign cv[0]    = vb;
  assign crem[0]  = mn_b >> 1;
  assign cdiv[0]  = mx_b;
  assign cquo[0]  = '0;
  assign cside[0] = side_b;

  for (genvar i = 0; i < QW; i++) begin : g_cell
    logic bit_in;
    if (i == 0) begin : g_first
      assign bit_in = mn_b[0];
    end else begin : g_rest
      assign bit_in = 1'b0;
    end

    atan2_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (cv[i]),
      .rem_in    (crem[i]),
      .bit_in    (bit_in),
      .div_in    (cdiv[i]),
      .quo_in    (cquo[i]),
      .side_in   (cside[i]),
      .out_valid (cv[i+1]),
      .rem_out   (crem[i+1]),
      .div_out   (cdiv[i+1]),
      .quo_out   (cquo[i+1]),
      .side_out  (cside[i+1])
    );
  end

  atan2_poly u_poly (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cv[QW]),
    .a_in      (cquo[QW]),
    .side_in   (cside[QW]),
    .out_valid (poly_valid),
    .angle     (angle)
  );

  assign m_tvalid = poly_valid;
  assign m_tdata  = atan2_pkg::OUT_DATA_W'(angle);

endmodule

// File: rtl/atan2_checker.sv
// ----------------------------------------------------------------------------
// atan2 port checker
// watches the top-level stream ports for handshake and flow-control slips
// ----------------------------------------------------------------------------
`include "atan2_polynomial_approx_top_defines.svh"

module atan2_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic [atan2_pkg::IN_DATA_W-1:0]  s_tdata,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [atan2_pkg::OUT_DATA_W-1:0] m_tdata
);

  logic in_seen;

  assign in_seen = s_tvalid && (s_tdata != '0);

  // output held while the receiver stalls
  `ATAN2_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // input side is open exactly when the output can move
  `ATAN2_ASSERT_NOW(a_ready_follows_out, 1'b1, s_tready == (!m_tvalid || m_tready))

  // no result straight after reset
  `ATAN2_ASSERT_RST(a_reset_empties, rst, !m_tvalid)

  // padding above the angle stays zero
  `ATAN2_ASSERT_NOW(a_pad_zero, m_tvalid || in_seen,
                    (m_tdata >> atan2_pkg::ANGLE_WIDTH) == '0)

endmodule

bind atan2_polynomial_approx_top atan2_checker u_atan2_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: sim/tb_atan2_polynomial_approx_top.sv
// ----------------------------------------------------------------------------
// atan2 pipeline testbench
// drives (y, x) vectors into the atan2 pipeline and checks each angle against
// a bit-exact fixed-point model of the quotient, polynomial and octant fold;
// directed corner vectors first, then random vectors under changing idle
// patterns, one long output stall and two full drains
// ----------------------------------------------------------------------------
module tb_atan2_polynomial_approx_top;

  localparam int CW = atan2_pkg::COORD_WIDTH;
  localparam int AFB = atan2_pkg::ANGLE_FRAC_BITS;
  localparam int AW = atan2_pkg::ANGLE_WIDTH;
  localparam int QFRAC = 16;

  localparam logic [63:0] COEF_C3 = 64'd3047;
  localparam logic [63:0] COEF_C2 = 64'd10441;
  localparam logic [63:0] COEF_C1 = 64'd21471;
  localparam logic [63:0] HALF_PI_Q16 = 64'd102944;
  localparam logic [63:0] PI_Q16 = 64'd205887;

  localparam int RANDOM_VECTORS = 1750;

  typedef struct {
    logic [CW-1:0] y;
    logic [CW-1:0] x;
    bit settle;
  } vector_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [atan2_pkg::IN_DATA_W-1:0] s_tdata = '0;  // y_coord, x_coord
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [atan2_pkg::OUT_DATA_W-1:0] m_tdata;      // angle

  vector_t vectors_pending[$];
  logic [AW-1:0] angles_due[$];
  int sent_count = 0;
  int results_seen = 0;
  int errors = 0;
  int stall_left = 0;
  bit stall_done = 1'b0;

  wire [1:0] phase = (sent_count < 600) ? 2'd0 : (sent_count < 1200) ? 2'd1 : 2'd2;
  wire [6:0] send_idle_pct = (phase == 2'd0) ? 7'd28 : (phase == 2'd1) ? 7'd65 : 7'd0;
  wire [6:0] take_idle_pct = (phase == 2'd0) ? 7'd65 : (phase == 2'd1) ? 7'd28 : 7'd0;

  atan2_polynomial_approx_top uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  function automatic logic [63:0] coord_mag(logic [CW-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    if (v[CW-1]) begin
      return (64'd1 << CW) - w;
    end
    return w;
  endfunction

  function automatic logic [AW-1:0] predict_angle(logic [CW-1:0] y, logic [CW-1:0] x);
    logic [63:0] ay, ax, mx, mn, a, s, t1, q, r, ang;
    ay = coord_mag(y);
    ax = coord_mag(x);
    if (ax == 0 && ay == 0) begin
      return '0;
    end
    mx = (ax > ay) ? ax : ay;
    mn = (ax > ay) ? ay : ax;
    a = (mn << QFRAC) / mx;
    s = (a * a) >> QFRAC;
    t1 = COEF_C2 - ((COEF_C3 * s) >> QFRAC);
    q = COEF_C1 - ((t1 * s) >> QFRAC);
    r = a - ((((q * s) >> QFRAC) * a) >> QFRAC);
    if (ay > ax) begin
      r = HALF_PI_Q16 - r;
    end
    if (x[CW-1]) begin
      r = PI_Q16 - r;
    end
    if (AFB >= QFRAC) begin
      ang = r << ((AFB >= QFRAC) ? AFB - QFRAC : 0);
    end else begin
      ang = (r + (64'd1 << ((AFB < QFRAC) ? QFRAC - AFB - 1 : 0)))
            >> ((AFB < QFRAC) ? QFRAC - AFB : 0);
    end
    if (y[CW-1]) begin
      ang = 64'd0 - ang;
    end
    return ang[AW-1:0];
  endfunction

  task automatic queue_vector(int y, int x, bit settle);
    vector_t v;
    v.y = CW'(y);
    v.x = CW'(x);
    v.settle = settle;
    vectors_pending.push_back(v);
  endtask

  function automatic int rand_sign(int m);
    return $urandom_range(1) ? -m : m;
  endfunction

  task automatic queue_random_vector(bit settle);
    int m, n, k;
    int corner[6];
    corner = '{-32768, -32767, -1, 0, 1, 32767};
    k = $urandom_range(9);
    case (k)
      0, 1, 2, 3: begin
        queue_vector(int'($signed(16'($urandom))), int'($signed(16'($urandom))), settle);
      end
      4, 5: begin
        queue_vector($urandom_range(32) - 16, $urandom_range(32) - 16, settle);
      end
      6: begin
        // magnitudes close together, around the diagonal
        m = $urandom_range(32767, 4);
        n = m - $urandom_range(3);
        if ($urandom_range(1)) begin
          queue_vector(rand_sign(m), rand_sign(n), settle);
        end else begin
          queue_vector(rand_sign(n), rand_sign(m), settle);
        end
      end
      7: begin
        m = int'($signed(16'($urandom)));
        if ($urandom_range(1)) begin
          queue_vector(m, 0, settle);
        end else begin
          queue_vector(0, m, settle);
        end
      end
      8: begin
        queue_vector(corner[$urandom_range(5)], corner[$urandom_range(5)], settle);
      end
      default: begin
        // steep vectors, small ratio on either side
        m = $urandom_range(32767, 1024);
        n = $urandom_range(m / 64);
        if ($urandom_range(1)) begin
          queue_vector(rand_sign(m), rand_sign(n), settle);
        end else begin
          queue_vector(rand_sign(n), rand_sign(m), settle);
        end
      end
    endcase
  endtask

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin : drive_proc
    vector_t v;
    int accept_now;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      accept_now = (s_tvalid && s_tready) ? 1 : 0;
      if (accept_now != 0) begin
        angles_due.push_back(predict_angle(s_tdata[CW-1:0], s_tdata[2*CW-1:CW]));
        sent_count <= sent_count + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (vectors_pending.size() != 0
            && !(vectors_pending[0].settle && (sent_count + accept_now) != results_seen)
            && $urandom_range(99) >= send_idle_pct) begin
          v = vectors_pending.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= atan2_pkg::IN_DATA_W'({v.x, v.y});
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : take_proc
    logic [AW-1:0] want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (angles_due.size() == 0) begin
          $error("angle with no vector outstanding: actual %0d", $signed(m_tdata[AW-1:0]));
          errors++;
        end else begin
          want = angles_due.pop_front();
          if (m_tdata[AW-1:0] !== want) begin
            $error("angle mismatch: expected %0d, actual %0d",
                   $signed(want), $signed(m_tdata[AW-1:0]));
            errors++;
          end
          results_seen <= results_seen + 1;
        end
      end
      // long output stall once the sender runs without gaps
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!stall_done && results_seen >= 1350) begin
        stall_done = 1'b1;
        stall_left = 300;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= take_idle_pct);
      end
    end
  end

  initial begin
    // zero vector and axes
    queue_vector(0, 0, 1'b0);
    queue_vector(0, 1, 1'b0);
    queue_vector(1, 0, 1'b0);
    queue_vector(-100, 0, 1'b0);
    queue_vector(0, -100, 1'b0);
    // equal magnitudes in all quadrants
    queue_vector(5, 5, 1'b0);
    queue_vector(-5, 5, 1'b0);
    queue_vector(5, -5, 1'b0);
    queue_vector(-5, -5, 1'b0);
    queue_vector(-32768, -32768, 1'b0);
    queue_vector(32767, 32767, 1'b0);
    // most negative coordinate
    queue_vector(-32768, 0, 1'b0);
    queue_vector(0, -32768, 1'b0);
    queue_vector(-32768, 32767, 1'b0);
    queue_vector(32767, -32768, 1'b0);
    queue_vector(-32768, 1, 1'b0);
    queue_vector(1, -32768, 1'b0);
    // extreme ratios
    queue_vector(32767, 1, 1'b0);
    queue_vector(1, 32767, 1'b0);
    queue_vector(-1, -1, 1'b0);
    queue_vector(-1, 32767, 1'b0);
    for (int i = 0; i < RANDOM_VECTORS; i++) begin
      queue_random_vector(i == 0 || i == 900);
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (vectors_pending.size() != 0 || s_tvalid) @(posedge clk);
    while (sent_count != results_seen) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: atan2_polynomial_approx_top.f
+incdir+rtl
rtl/atan2_pkg.sv
rtl/atan2_div_cell.sv
rtl/atan2_poly.sv
rtl/atan2_polynomial_approx_top.sv
rtl/atan2_checker.sv
sim/tb_atan2_polynomial_approx_top.sv
